[hdl/cic_pkg.sv]
// shared types, codes and priority helpers for the cascaded interrupt controller
// no dependencies
`timescale 1ns / 1ps
package cic_pkg;

  typedef enum logic [2:0] {
    MODE_READ    = 3'd0,
    MODE_WRITE   = 3'd1,
    MODE_RAISE   = 3'd2,
    MODE_ACK     = 3'd3,
    MODE_PEEK    = 3'd4,
    MODE_CASCADE = 3'd5
  } mode_t;

  localparam logic [2:0] CASCADE_LINE = 3'd2;

  typedef struct packed {
    logic [7:0] irr;
    logic [7:0] isr;
    logic [7:0] imr;
    logic [7:0] icw1;
    logic [7:0] icw2;
    logic [7:0] icw3;
    logic [7:0] icw4;
    logic [7:0] ocw2;
    logic [7:0] ocw3;
    logic [2:0] top;
    logic [2:0] phase;
  } chip_t;

  // found flag in bit 3, level in bits 2:0
  function automatic logic [3:0] top_level(input logic [2:0] top, input logic [7:0] bits);
    logic [15:0] dbl;
    logic [7:0]  rot;
    logic [3:0]  res;
    dbl = {bits, bits} >> top;
    rot = dbl[7:0];
    res = 4'd0;
    for (int k = 7; k >= 0; k--) begin
      if (rot[k]) res = {1'b1, top + 3'(k)};
    end
    return res;
  endfunction

  // distance of a level from the top priority
  function automatic logic [2:0] rank(input logic [2:0] top, input logic [2:0] lv);
    return lv - top;
  endfunction

  function automatic logic chip_intr(input chip_t c);
    logic [3:0] rq;
    logic [3:0] sv;
    rq = top_level(c.top, c.irr & ~c.imr);
    sv = top_level(c.top, c.isr);
    if (!rq[3]) return 1'b0;
    if (!sv[3]) return 1'b1;
    if (c.icw4[4]) return rank(c.top, rq[2:0]) <= rank(c.top, sv[2:0]);
    return rank(c.top, rq[2:0]) < rank(c.top, sv[2:0]);
  endfunction

endpackage

[hdl/cic_chip_write.sv]
// port write decode for one controller: init words, mask, ocw2 and ocw3
// depends on cic_pkg
`timescale 1ns / 1ps
module cic_chip_write (
  input  cic_pkg::chip_t     chip_in,
  input  logic               port_a0,
  input  logic [7:0]         data,
  output cic_pkg::chip_t     chip_out
);
  import cic_pkg::*;

  logic [3:0] svl;
  logic [2:0] lv;
  logic [7:0] clr;

  always_comb begin
    chip_out = chip_in;
    svl = top_level(chip_in.top, chip_in.isr);
    lv  = 3'd0;
    clr = 8'd0;
    if (!port_a0) begin
      if (data[4]) begin
        chip_out.icw1  = data;
        chip_out.phase = 3'd1;
        if (!data[0]) chip_out.icw4 = 8'd0;
      end else if (data[3]) begin
        if (data[6]) chip_out.ocw3 = data;
        else chip_out.ocw3 = (chip_in.ocw3 & 8'h20) | (data & ~8'h20);
      end else begin
        case (data[7:5])
          3'b100, 3'b000: if (chip_in.icw4[1]) chip_out.ocw2 = data;
          3'b001, 3'b101, 3'b011, 3'b111: begin
            chip_out.ocw2 = data;
            lv = data[6] ? data[2:0] : svl[2:0];
            if (chip_in.isr != 8'd0) begin
              clr = 8'd1 << lv;
              chip_out.isr = chip_in.isr & ~clr;
              if (data[7]) chip_out.top = lv + 3'd1;
            end
          end
          3'b110: begin
            chip_out.ocw2 = data;
            chip_out.top  = data[2:0] + 3'd1;
          end
          default: ;
        endcase
      end
    end else begin
      case (chip_in.phase)
        3'd1: begin
          chip_out.icw2 = data & 8'hf8;
          if (!chip_in.icw1[1]) chip_out.phase = 3'd2;
          else if (chip_in.icw1[0]) chip_out.phase = 3'd3;
          else chip_out.phase = 3'd4;
        end
        3'd2: begin
          chip_out.icw3  = data;
          chip_out.phase = chip_in.icw1[0] ? 3'd3 : 3'd4;
        end
        3'd3: begin
          chip_out.icw4  = data & 8'h1f;
          chip_out.phase = 3'd4;
        end
        3'd4: begin
          chip_out.imr = data;
          if (chip_in.ocw3[5]) chip_out.isr = chip_in.isr & ~data;
        end
        default: ;
      endcase
    end
  end
endmodule

[hdl/cascaded_interrupt_controller_core.sv]
// top level of the cascaded interrupt controller pair
// depends on cic_pkg and cic_chip_write
//
// usage: one event per input transfer (port read/write, irq raise,
// acknowledge, peek, cascade refresh). every event gives one result
// transfer carrying read_data, vector and the interrupt-pending flag after the event.
// the result is registered and appears in the cycle after the input transfer.
// throughput: one event per cycle while the result is not stalled; the event is applied to the chip
// registers and the result register in the same edge.
// a stalled result holds in the output register; the input side stalls
// only while that register is full and not being taken.
// reset: both controllers await icw1, all registers clear, ocw3 selects
// the request register for command reads, and the output register empties.
//
`timescale 1ns / 1ps
module cascaded_interrupt_controller_core #(
  parameter int LINES_PER_CHIP = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_mode,
  input  logic       in_chip_select,
  input  logic       in_port_a0,
  input  logic [7:0] in_write_data,
  input  logic [3:0] in_irq_number,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic [7:0] out_vector,
  output logic       out_intr_pending
);
  import cic_pkg::*;

  chip_t chip_r [2];
  chip_t chip_nxt [2];
  chip_t wr_in, wr_out;
  logic [7:0] rd, vec;
  logic [3:0] mq, sq, ml, sl;
  logic go;
  chip_t c0, c1;
  logic [7:0] bit0, bit1;

  assign in_stall = out_valid && out_stall;
  assign go = in_valid && !in_stall;
  assign wr_in = chip_r[in_chip_select];

  cic_chip_write u_wr (
    .chip_in(wr_in), .port_a0(in_port_a0), .data(in_write_data), .chip_out(wr_out)
  );

  always_comb begin
    chip_nxt = chip_r;
    rd = 8'd0;
    vec = 8'd0;
    c0 = chip_r[0];
    c1 = chip_r[1];
    mq = top_level(c0.top, c0.irr & ~c0.imr);
    sq = top_level(c1.top, c1.irr & ~c1.imr);
    bit0 = 8'd1 << mq[2:0];
    bit1 = 8'd1 << sq[2:0];
    case (in_mode)
      MODE_READ: begin
        if (in_port_a0) rd = wr_in.imr;
        else if (wr_in.ocw3[2]) begin
          ml = top_level(wr_in.top, wr_in.irr & ~wr_in.imr);
          rd = ml[3] ? {5'b10000, ml[2:0]} : 8'd0;
        end else begin
          case (wr_in.ocw3[1:0])
            2'b10: rd = wr_in.irr;
            2'b11: rd = wr_in.isr;
            default: rd = 8'd0;
          endcase
        end
      end
      MODE_WRITE: chip_nxt[in_chip_select] = wr_out;
      MODE_RAISE: begin
        if (in_irq_number[3]) begin
          chip_nxt[0].irr = c0.irr | 8'h04;
          chip_nxt[1].irr = c1.irr | (8'd1 << in_irq_number[2:0]);
        end else if (in_irq_number[2:0] != CASCADE_LINE) begin
          chip_nxt[0].irr = c0.irr | (8'd1 << in_irq_number[2:0]);
        end
      end
      MODE_ACK, MODE_PEEK: begin
        if (!mq[3]) vec = c0.icw2 | 8'h07;
        else begin
          if (mq[2:0] != CASCADE_LINE) vec = c0.icw2 | {5'd0, mq[2:0]};
          else if (!sq[3]) vec = c1.icw2 | 8'h07;
          else vec = c1.icw2 | {5'd0, sq[2:0]};
          if (in_mode == MODE_ACK) begin
            chip_nxt[0].irr = c0.irr & ~bit0;
            chip_nxt[0].isr = c0.icw4[1] ? (c0.isr & ~bit0) : (c0.isr | bit0);
            if (c0.icw4[1] && c0.ocw2[7]) chip_nxt[0].top = mq[2:0] + 3'd1;
            if (mq[2:0] == CASCADE_LINE && sq[3]) begin
              chip_nxt[1].irr = c1.irr & ~bit1;
              chip_nxt[1].isr = c1.icw4[1] ? (c1.isr & ~bit1) : (c1.isr | bit1);
              if (c1.icw4[1] && c1.ocw2[7]) chip_nxt[1].top = sq[2:0] + 3'd1;
            end
          end
        end
      end
      MODE_CASCADE: begin
        if ((c1.irr & ~c1.imr) != 8'd0) chip_nxt[0].irr = c0.irr | 8'h04;
        else chip_nxt[0].irr = c0.irr & ~8'h04;
      end
      default: ;
    endcase
    ml = top_level(chip_nxt[0].top, chip_nxt[0].irr & ~chip_nxt[0].imr);
    sl = {3'd0, chip_intr(chip_nxt[0])};
    if (sl[0] && ml[3] && ml[2:0] == CASCADE_LINE) sl[0] = chip_intr(chip_nxt[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // everything clear except ocw3, which selects the request register
      for (int i = 0; i < 2; i++) begin
        chip_r[i] <= chip_t'({64'd0, 8'h02, 6'd0});
      end
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        chip_r <= chip_nxt;
        out_read_data <= rd;
        out_vector <= vec;
        out_intr_pending <= sl[0];
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vector) && $stable(out_read_data))
    else $error("result changed under stall");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");
  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_mode != MODE_ACK && in_mode != MODE_PEEK |=> out_vector == 8'd0)
    else $error("vector on non-ack event");
  a_lines: assert property (@(posedge clk) LINES_PER_CHIP == 8)
    else $error("unsupported line count");
endmodule

[tb/cascaded_interrupt_controller_core_tb.sv]
// self-checking testbench for the cascaded interrupt controller core
// depends on cic_pkg and cascaded_interrupt_controller_core; predicts each result in-line
`timescale 1ns / 1ps
module cascaded_interrupt_controller_core_tb;
  import cic_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_mode;
  logic       in_chip_select;
  logic       in_port_a0;
  logic [7:0] in_write_data;
  logic [3:0] in_irq_number;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;
  logic [7:0] out_vector;
  logic       out_intr_pending;

  cascaded_interrupt_controller_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_chip_select(in_chip_select), .in_port_a0(in_port_a0),
    .in_write_data(in_write_data), .in_irq_number(in_irq_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_vector(out_vector),
    .out_intr_pending(out_intr_pending)
  );

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] vec;
    logic       intr;
  } pic_result_t;

  // predicted chip state, index 0 master, 1 slave
  logic [7:0] p_irr [2];
  logic [7:0] p_isr [2];
  logic [7:0] p_imr [2];
  logic [7:0] p_icw [8];
  logic [7:0] p_ocw2 [2];
  logic [7:0] p_ocw3 [2];
  logic [2:0] p_top [2];
  logic [2:0] p_phase [2];

  pic_result_t pending_results[$];
  int          mismatches;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // returns 8 when no bit set
  function automatic int find_top(int c, logic [7:0] bits);
    int lv;
    for (int k = 0; k < 8; k++) begin
      lv = (p_top[c] + k) % 8;
      if (bits[lv]) return lv;
    end
    return 8;
  endfunction

  function automatic int top_req(int c);
    return find_top(c, p_irr[c] & ~p_imr[c]);
  endfunction

  function automatic bit chip_pending(int c);
    int rq;
    int sv;
    rq = top_req(c);
    sv = find_top(c, p_isr[c]);
    if (rq == 8) return 1'b0;
    if (sv == 8) return 1'b1;
    if (rq < p_top[c]) rq += 8;
    if (sv < p_top[c]) sv += 8;
    if (p_icw[c*4+3][4]) return rq <= sv;
    return rq < sv;
  endfunction

  task automatic service_level(int c, int lv);
    p_isr[c][lv] = 1'b1;
    p_irr[c][lv] = 1'b0;
    if (p_icw[c*4+3][1]) begin
      p_isr[c][lv] = 1'b0;
      if (p_ocw2[c][7]) p_top[c] = 3'((lv + 1) % 8);
    end
  endtask

  task automatic ack_vector(bit commit, output logic [7:0] vec);
    int m;
    int s;
    m = top_req(0);
    if (m == 8) begin
      vec = p_icw[1] | 8'h07;
      return;
    end
    if (commit) service_level(0, m);
    if (m != CASCADE_LINE) begin
      vec = p_icw[1] | 8'(m);
      return;
    end
    s = top_req(1);
    if (s == 8) begin
      vec = p_icw[5] | 8'h07;
      return;
    end
    if (commit) service_level(1, s);
    vec = p_icw[5] | 8'(s);
  endtask

  task automatic cmd_write(int c, logic [7:0] b);
    int lv;
    bit aeoi;
    aeoi = p_icw[c*4+3][1];
    if (b[4]) begin
      p_icw[c*4] = b;
      p_phase[c] = 3'd1;
      if (!b[0]) p_icw[c*4+3] = 8'h00;
      return;
    end
    if (b[3]) begin
      if (b[6]) p_ocw3[c] = b;
      else p_ocw3[c] = (p_ocw3[c] & 8'h20) | (b & 8'hdf);
      return;
    end
    case (b & 8'he0)
      8'h80, 8'h00: if (aeoi) p_ocw2[c] = b;
      8'h20, 8'ha0: begin
        p_ocw2[c] = b;
        if (p_isr[c] != 0) begin
          lv = find_top(c, p_isr[c]);
          p_isr[c][lv] = 1'b0;
          if (b[7]) p_top[c] = 3'((lv + 1) % 8);
        end
      end
      8'h60, 8'he0: begin
        p_ocw2[c] = b;
        if (p_isr[c] != 0) begin
          lv = b[2:0];
          p_isr[c][lv] = 1'b0;
          if (b[7]) p_top[c] = 3'((lv + 1) % 8);
        end
      end
      8'hc0: begin
        p_ocw2[c] = b;
        p_top[c] = b[2:0] + 3'd1;
      end
      default: ;
    endcase
  endtask

  task automatic data_write(int c, logic [7:0] b);
    logic [7:0] icw1;
    icw1 = p_icw[c*4];
    case (p_phase[c])
      3'd1: begin
        p_icw[c*4+1] = b & 8'hf8;
        if (!icw1[1]) p_phase[c] = 3'd2;
        else if (icw1[0]) p_phase[c] = 3'd3;
        else p_phase[c] = 3'd4;
      end
      3'd2: begin
        p_icw[c*4+2] = b;
        p_phase[c] = icw1[0] ? 3'd3 : 3'd4;
      end
      3'd3: begin
        p_icw[c*4+3] = b & 8'h1f;
        p_phase[c] = 3'd4;
      end
      3'd4: begin
        p_imr[c] = b;
        if (p_ocw3[c][5]) p_isr[c] = p_isr[c] & ~p_imr[c];
      end
      default: ;
    endcase
  endtask

  task automatic predict_event(logic [2:0] md, int c, logic a0, logic [7:0] b, logic [3:0] irq);
    pic_result_t r;
    int t;
    r = '0;
    case (md)
      MODE_READ: begin
        if (a0) r.rd = p_imr[c];
        else if (p_ocw3[c][2]) begin
          t = top_req(c);
          r.rd = (t == 8) ? 8'h00 : (8'h80 | 8'(t));
        end else if (p_ocw3[c][1:0] == 2'b10) r.rd = p_irr[c];
        else if (p_ocw3[c][1:0] == 2'b11) r.rd = p_isr[c];
      end
      MODE_WRITE: if (a0) data_write(c, b); else cmd_write(c, b);
      MODE_RAISE: begin
        if (irq >= 8) begin
          p_irr[0][2] = 1'b1;
          p_irr[1][irq-8] = 1'b1;
        end else if (irq != 2) p_irr[0][irq] = 1'b1;
      end
      MODE_ACK: ack_vector(1'b1, r.vec);
      MODE_PEEK: ack_vector(1'b0, r.vec);
      MODE_CASCADE: p_irr[0][2] = ((p_irr[1] & ~p_imr[1]) != 0);
      default: ;
    endcase
    r.intr = chip_pending(0);
    if (r.intr && top_req(0) == CASCADE_LINE) r.intr = chip_pending(1);
    pending_results.push_back(r);
  endtask

  // valid stays high after a transfer until the next idle cycle or drain
  task automatic send_event(logic [2:0] md, logic c, logic a0, logic [7:0] b, logic [3:0] irq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_chip_select <= c;
    in_port_a0 <= a0;
    in_write_data <= b;
    in_irq_number <= irq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_event(md, c, a0, b, irq);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    pic_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer rd=%h vec=%h intr=%b",
                                       out_read_data, out_vector, out_intr_pending);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_read_data !== exp_r.rd || out_vector !== exp_r.vec ||
            out_intr_pending !== exp_r.intr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rd=%h vec=%h intr=%b, got rd=%h vec=%h intr=%b",
                     exp_r.rd, exp_r.vec, exp_r.intr,
                     out_read_data, out_vector, out_intr_pending);
        end
      end
    end
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic init_chip(logic c, logic [7:0] icw1, logic [7:0] icw2, logic [7:0] icw4);
    send_event(MODE_WRITE, c, 1'b0, icw1, 4'd0);
    send_event(MODE_WRITE, c, 1'b1, icw2, 4'd0);
    if (!icw1[1]) send_event(MODE_WRITE, c, 1'b1, c ? 8'h02 : 8'h04, 4'd0);
    if (icw1[0]) send_event(MODE_WRITE, c, 1'b1, icw4, 4'd0);
  endtask

  task automatic test_directed();
    send_event(MODE_WRITE, 1'b0, 1'b1, 8'hff, 4'd0);
    send_event(MODE_READ, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_PEEK, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(3'd6, 1'b1, 1'b1, 8'haa, 4'd15);
    send_event(3'd7, 1'b0, 1'b0, 8'h55, 4'd0);
    init_chip(1'b0, 8'h11, 8'h08, 8'h00);
    init_chip(1'b1, 8'h11, 8'h70, 8'h1f);
    send_event(MODE_RAISE, 1'b0, 1'b0, 8'h00, 4'd2);
    send_event(MODE_RAISE, 1'b0, 1'b0, 8'h00, 4'd7);
    send_event(MODE_RAISE, 1'b0, 1'b0, 8'h00, 4'd15);
    send_event(MODE_RAISE, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_ACK, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_ACK, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_WRITE, 1'b0, 1'b0, 8'h0b, 4'd0);
    send_event(MODE_READ, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_WRITE, 1'b0, 1'b0, 8'h0c, 4'd0);
    send_event(MODE_READ, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_WRITE, 1'b0, 1'b0, 8'he0, 4'd0);
    send_event(MODE_WRITE, 1'b0, 1'b0, 8'h68, 4'd0);
    send_event(MODE_WRITE, 1'b0, 1'b1, 8'h04, 4'd0);
    send_event(MODE_CASCADE, 1'b0, 1'b0, 8'h00, 4'd0);
    send_event(MODE_WRITE, 1'b0, 1'b0, 8'hc7, 4'd0);
    send_event(MODE_READ, 1'b1, 1'b1, 8'h00, 4'd0);
    drain_results();
  endtask

  function automatic logic [7:0] pick_write(logic a0);
    int k;
    k = $urandom_range(9);
    if (a0) return 8'($urandom);
    case (k)
      0:       return 8'h10 | 8'($urandom_range(15)) | (8'($urandom_range(7)) << 5);
      1, 2:    return 8'h20 | (8'($urandom_range(1)) << 7);
      3, 4:    return 8'h60 | 8'($urandom_range(7)) | (8'($urandom_range(1)) << 7);
      5:       return 8'hc0 | 8'($urandom_range(7));
      6, 7:    return 8'h08 | 8'($urandom_range(7)) | (8'($urandom_range(7)) << 5);
      default: return 8'($urandom) & 8'hef;
    endcase
  endfunction

  task automatic test_random(int count);
    logic [2:0] md;
    logic       c;
    logic       a0;
    int         k;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        init_chip(1'b0, 8'h11 | (8'($urandom_range(1)) << 3), 8'($urandom),
                  8'($urandom) & 8'h1f);
        init_chip(1'b1, 8'h10 | 8'($urandom_range(3)), 8'($urandom), 8'($urandom));
      end
      k = $urandom_range(99);
      c = $urandom_range(1);
      a0 = $urandom_range(1);
      if (k < 30) md = MODE_RAISE;
      else if (k < 50) md = MODE_ACK;
      else if (k < 58) md = MODE_PEEK;
      else if (k < 80) md = MODE_WRITE;
      else if (k < 92) md = MODE_READ;
      else if (k < 98) md = MODE_CASCADE;
      else md = 3'($urandom_range(7));
      if (md == MODE_WRITE && a0 && $urandom_range(3) != 0) a0 = 1'b0;
      send_event(md, c, a0, pick_write(a0), 4'($urandom));
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_chip_select = 1'b0;
    in_port_a0 = 1'b0;
    in_write_data = '0;
    in_irq_number = '0;
    out_stall = 1'b0;
    mismatches = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int c = 0; c < 2; c++) begin
      p_irr[c] = '0; p_isr[c] = '0; p_imr[c] = '0;
      p_ocw2[c] = '0; p_ocw3[c] = 8'h02; p_top[c] = '0; p_phase[c] = '0;
    end
    for (int i = 0; i < 8; i++) p_icw[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 33; recv_idle_pct = 78;
    test_directed();
    test_random(530);
    send_idle_pct = 78; recv_idle_pct = 33;
    test_random(530);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(530);
    repeat (10) @(posedge clk);
    $display("covered init sequences, masking, eoi and rotation, poll and reads, cascade acks");
    $display("result transfers checked: %0d, mismatches: %0d", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
